// File: sv/two_hand_shortest_arc_mover_core_defines.svh
// ---------------------------------------------------------------------------
// two_hand_shortest_arc_mover_core_defines
// assertion macros for the file that checks the mover core
// ---------------------------------------------------------------------------
`ifndef TWO_HAND_SHORTEST_ARC_MOVER_CORE_DEFINES_SVH
`define TWO_HAND_SHORTEST_ARC_MOVER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define THSAM_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define THSAM_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: sv/thsam_pkg.sv
// ---------------------------------------------------------------------------
// thsam_pkg
// shared types and constants of the two-hand shortest-arc mover
// ---------------------------------------------------------------------------
package thsam_pkg;

   localparam int unsigned ANGLE_FRAC_BITS = 4;
   localparam int unsigned MAX_STEPS       = 63;

   localparam int unsigned ANGLE_W    = 13;
   localparam int unsigned ARC_W      = 12;
   localparam int unsigned RATE_W     = 12;
   localparam int unsigned INDEX_W    = 6;
   localparam int unsigned PROD_W     = ARC_W + RATE_W;
   localparam int unsigned STEP_SHIFT = ANGLE_FRAC_BITS + 8;

   localparam logic [ANGLE_W-1:0] FULL_TURN   = ANGLE_W'(360 << ANGLE_FRAC_BITS);
   localparam logic [ANGLE_W-1:0] HALF_TURN   = ANGLE_W'(180 << ANGLE_FRAC_BITS);
   localparam logic [INDEX_W-1:0] MAX_STEPS_V = INDEX_W'(MAX_STEPS);
   localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(64);

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned DIV_CNT_W = $clog2(ARC_W + 1);

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_STEP_RATE = '0;

   typedef enum logic {
      OP_MOVE = 1'b0,
      OP_SET  = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [ANGLE_W-1:0] target_a;
      logic [ANGLE_W-1:0] target_b;
   } cmd_type;

   typedef struct packed {
      logic               start;
      logic [ARC_W-1:0]   dividend;
      logic [INDEX_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [ARC_W-1:0]   quot;
      logic [INDEX_W-1:0] rem;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAIR,
      ST_SCALE,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_EMIT
   } back_state_type;

endpackage

// File: sv/two_hand_shortest_arc_mover_core.sv
// ---------------------------------------------------------------------------
// two_hand_shortest_arc_mover_core
// two hands on shortest arcs, one interpolation point per unstalled cycle
// ---------------------------------------------------------------------------
// Commands enter a four-deep queue at one per cycle while it has room. A set
// command is applied straight from idle in the back end and gives no result.
// A move command is first planned (pairing, arcs, the step-rate multiply and
// a 12-bit bit-serial division of each arc by the step count) and then gives
// steps+1 points, one per cycle while rsp_ready stays high. The step count is
// max(1, min(63, largest_arc * step_rate / 4096)). The result register lets
// the block keep accepting commands while a point waits to be taken.
`include "two_hand_shortest_arc_mover_core_defines.svh"

module two_hand_shortest_arc_mover_core import thsam_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [ANGLE_W-1:0]    req_target_a,
   input  logic [ANGLE_W-1:0]    req_target_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ANGLE_W-1:0]    rsp_angle_a,
   output logic [ANGLE_W-1:0]    rsp_angle_b,
   output logic [INDEX_W-1:0]    rsp_step_index,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [RATE_W-1:0]     step_rate_ff, step_rate_in;
   logic [CSR_ADDR_W-3:0] csr_index;
   logic                  csr_write;

   logic        push, queue_full, queue_empty, pop;
   cmd_type     push_cmd, pop_cmd;
   div_req_type div_req_a, div_req_b;
   div_rsp_type div_rsp_a, div_rsp_b;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      step_rate_in = step_rate_ff;
      if (csr_write && (csr_index == REG_STEP_RATE)) begin
         step_rate_in = csr_pwdata[RATE_W-1:0];
      end
      csr_prdata = (csr_index == REG_STEP_RATE) ? CSR_DATA_W'(step_rate_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_rate_ff <= RATE_RESET;
      end else begin
         step_rate_ff <= step_rate_in;
      end
   end

   thsam_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_target_a (req_target_a),
      .req_target_b (req_target_b),
      .queue_full   (queue_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   thsam_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   thsam_div u_div_a (
      .clock (clock),
      .reset (reset),
      .req   (div_req_a),
      .rsp   (div_rsp_a)
   );

   thsam_div u_div_b (
      .clock (clock),
      .reset (reset),
      .req   (div_req_b),
      .rsp   (div_rsp_b)
   );

   thsam_back u_back (
      .clock          (clock),
      .reset          (reset),
      .step_rate      (step_rate_ff),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .pop_cmd        (pop_cmd),
      .div_req_a      (div_req_a),
      .div_req_b      (div_req_b),
      .div_rsp_a      (div_rsp_a),
      .div_rsp_b      (div_rsp_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_angle_a    (rsp_angle_a),
      .rsp_angle_b    (rsp_angle_b),
      .rsp_step_index (rsp_step_index),
      .rsp_last       (rsp_last)
   );

   // a run always has at least two points
   `THSAM_ASSERT_NOW(a_last_not_first, rsp_valid && rsp_last, rsp_step_index != '0, "last point at index zero")
   // points of a run come in index order
   `THSAM_ASSERT_NOW(a_index_order, (rsp_valid && rsp_ready && !rsp_last) ##1 rsp_valid, rsp_step_index == INDEX_W'($past(rsp_step_index) + 1'b1), "point index skipped")
   // both divider lanes run in lock step
   `THSAM_ASSERT_NOW(a_div_lockstep, div_rsp_a.done || div_rsp_b.done, div_rsp_a.done && div_rsp_b.done, "divider lanes out of step")
   // an accepted item is held in the queue
   `THSAM_ASSERT_NEXT(a_item_queued, req_valid && req_ready, !queue_empty, "accepted item missing from queue")

endmodule

// File: sv/thsam_front.sv
// ---------------------------------------------------------------------------
// thsam_front
// accepts commands, folds targets into one turn and queues them
// ---------------------------------------------------------------------------
module thsam_front import thsam_pkg::*; (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [ANGLE_W-1:0] req_target_a,
   input  logic [ANGLE_W-1:0] req_target_b,
   input  logic               queue_full,
   output logic               push,
   output cmd_type            push_cmd
);

   function automatic logic [ANGLE_W-1:0] fold_turn(input logic [ANGLE_W-1:0] t);
      // the field range is below two turns, so one subtract is enough
      return (t >= FULL_TURN) ? ANGLE_W'(t - FULL_TURN) : t;
   endfunction

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_cmd.op       = op_type'(req_op);
      push_cmd.target_a = fold_turn(req_target_a);
      push_cmd.target_b = fold_turn(req_target_b);
   end

endmodule

// File: sv/thsam_fifo.sv
// ---------------------------------------------------------------------------
// thsam_fifo
// short command queue between the front and the back
// ---------------------------------------------------------------------------
module thsam_fifo import thsam_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
      return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : QUEUE_PTR_W'(p + 1'b1);
   endfunction

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = QUEUE_CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = QUEUE_CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: sv/thsam_div.sv
// ---------------------------------------------------------------------------
// thsam_div
// restoring divider, one quotient bit per cycle, arc magnitude by step count
// ---------------------------------------------------------------------------
module thsam_div import thsam_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ARC_W-1:0]     quot_ff, quot_in;
   logic [INDEX_W-1:0]   rem_ff, rem_in;
   logic [INDEX_W-1:0]   divisor_ff, divisor_in;
   logic [INDEX_W:0]     trial;
   logic [INDEX_W:0]     diff;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, quot_ff[ARC_W-1]};
      fits  = (trial >= {1'b0, divisor_ff});
      diff  = trial - {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(ARC_W);
         quot_in    = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         quot_in = {quot_ff[ARC_W-2:0], fits};
         rem_in  = fits ? diff[INDEX_W-1:0] : trial[INDEX_W-1:0];
         cnt_in  = DIV_CNT_W'(cnt_ff - 1'b1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      rsp.done = done_ff;
      rsp.quot = quot_ff;
      rsp.rem  = rem_ff;
   end

endmodule

// File: sv/thsam_back.sv
// ---------------------------------------------------------------------------
// thsam_back
// plans each move (pairing, arcs, step count), walks its points and applies sets
// ---------------------------------------------------------------------------
module thsam_back import thsam_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [RATE_W-1:0]  step_rate,
   input  logic               queue_empty,
   output logic               pop,
   input  cmd_type            pop_cmd,
   output div_req_type        div_req_a,
   output div_req_type        div_req_b,
   input  div_rsp_type        div_rsp_a,
   input  div_rsp_type        div_rsp_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ANGLE_W-1:0] rsp_angle_a,
   output logic [ANGLE_W-1:0] rsp_angle_b,
   output logic [INDEX_W-1:0] rsp_step_index,
   output logic               rsp_last
);

   back_state_type state_ff, state_in;

   logic [ANGLE_W-1:0] hand_a_ff, hand_a_in;
   logic [ANGLE_W-1:0] hand_b_ff, hand_b_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [ANGLE_W-1:0] tgt_a_ff, tgt_b_ff;
   logic [ANGLE_W-1:0] start_a_ff, start_b_ff;
   logic [ANGLE_W-1:0] delta_a_ff, delta_b_ff;
   logic [ARC_W-1:0]   arc_ff;
   logic [INDEX_W-1:0] steps_ff;
   logic [ARC_W-1:0]   inc_q_a_ff, inc_q_b_ff;
   logic [INDEX_W-1:0] inc_r_a_ff, inc_r_b_ff;
   logic [ARC_W-1:0]   quo_a_ff, quo_a_in, quo_b_ff, quo_b_in;
   logic [INDEX_W-1:0] rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [INDEX_W-1:0] index_ff;
   logic [ANGLE_W-1:0] out_a_ff, out_b_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic               out_last_ff;

   logic do_set, load_cmd, do_pair, do_scale, div_start, div_latch, emit;

   logic [ANGLE_W:0]   cost_swap, cost_keep;
   logic               swap;
   logic [ANGLE_W-1:0] end_a, end_b;
   logic [ANGLE_W-1:0] pair_delta_a, pair_delta_b;
   logic [ARC_W-1:0]   pair_arc_a, pair_arc_b;
   logic [PROD_W-1:0]  scale_prod, scale_raw;
   logic [INDEX_W-1:0] scale_steps;
   logic [ANGLE_W-1:0] mag_a, mag_b;
   logic               is_last;
   logic [ANGLE_W-1:0] pos_a, pos_b;
   logic [INDEX_W:0]   rsum_a, rsum_b;
   logic               carry_a, carry_b;

   function automatic logic [ANGLE_W-1:0] absdiff(input logic [ANGLE_W-1:0] x,
                                                  input logic [ANGLE_W-1:0] y);
      return (x >= y) ? ANGLE_W'(x - y) : ANGLE_W'(y - x);
   endfunction

   // signed shortest-arc delta in [-half, half)
   function automatic logic [ANGLE_W-1:0] arc_delta(input logic [ANGLE_W-1:0] from_a,
                                                    input logic [ANGLE_W-1:0] to_a);
      logic signed [ANGLE_W+1:0] x;
      x = $signed((ANGLE_W+2)'(to_a)) - $signed((ANGLE_W+2)'(from_a))
          + $signed((ANGLE_W+2)'(HALF_TURN));
      if (x < 0) begin
         x = x + $signed((ANGLE_W+2)'(FULL_TURN));
      end else if (x >= $signed((ANGLE_W+2)'(FULL_TURN))) begin
         x = x - $signed((ANGLE_W+2)'(FULL_TURN));
      end
      x = x - $signed((ANGLE_W+2)'(HALF_TURN));
      return x[ANGLE_W-1:0];
   endfunction

   function automatic logic [ARC_W-1:0] arc_len(input logic [ANGLE_W-1:0] x,
                                                input logic [ANGLE_W-1:0] y);
      logic [ANGLE_W-1:0] d;
      d = absdiff(x, y);
      if (d > HALF_TURN) begin
         d = ANGLE_W'(FULL_TURN - d);
      end
      return d[ARC_W-1:0];
   endfunction

   function automatic logic [ANGLE_W-1:0] wrap_pos(input logic [ANGLE_W-1:0] base,
                                                   input logic [ARC_W-1:0]   mag,
                                                   input logic               neg);
      logic signed [ANGLE_W+1:0] s;
      s = $signed((ANGLE_W+2)'(base));
      if (neg) begin
         s = s - $signed((ANGLE_W+2)'(mag));
      end else begin
         s = s + $signed((ANGLE_W+2)'(mag));
      end
      if (s < 0) begin
         s = s + $signed((ANGLE_W+2)'(FULL_TURN));
      end else if (s >= $signed((ANGLE_W+2)'(FULL_TURN))) begin
         s = s - $signed((ANGLE_W+2)'(FULL_TURN));
      end
      return s[ANGLE_W-1:0];
   endfunction

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      do_set    = 1'b0;
      load_cmd  = 1'b0;
      do_pair   = 1'b0;
      do_scale  = 1'b0;
      div_start = 1'b0;
      div_latch = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (pop_cmd.op == OP_SET) begin
                  do_set = 1'b1;
               end else begin
                  load_cmd = 1'b1;
                  state_in = ST_PAIR;
               end
            end
         end
         ST_PAIR: begin
            do_pair  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            do_scale = 1'b1;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_rsp_a.done) begin
               div_latch = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // move planning
   always_comb begin
      cost_swap = {1'b0, absdiff(tgt_b_ff, hand_a_ff)} + {1'b0, absdiff(tgt_a_ff, hand_b_ff)};
      cost_keep = {1'b0, absdiff(tgt_a_ff, hand_a_ff)} + {1'b0, absdiff(tgt_b_ff, hand_b_ff)};
      swap      = (cost_swap < cost_keep);
      end_a     = swap ? tgt_b_ff : tgt_a_ff;
      end_b     = swap ? tgt_a_ff : tgt_b_ff;

      pair_delta_a = arc_delta(hand_a_ff, end_a);
      pair_delta_b = arc_delta(hand_b_ff, end_b);
      pair_arc_a   = arc_len(end_a, hand_a_ff);
      pair_arc_b   = arc_len(end_b, hand_b_ff);

      scale_prod = PROD_W'(arc_ff) * PROD_W'(step_rate);
      scale_raw  = scale_prod >> STEP_SHIFT;
      if (scale_raw == '0) begin
         scale_steps = INDEX_W'(1);
      end else if (scale_raw > PROD_W'(MAX_STEPS)) begin
         scale_steps = MAX_STEPS_V;
      end else begin
         scale_steps = scale_raw[INDEX_W-1:0];
      end

      mag_a = delta_a_ff[ANGLE_W-1] ? ANGLE_W'(~delta_a_ff + 1'b1) : delta_a_ff;
      mag_b = delta_b_ff[ANGLE_W-1] ? ANGLE_W'(~delta_b_ff + 1'b1) : delta_b_ff;
   end

   always_comb begin
      div_req_a.start    = div_start;
      div_req_a.dividend = mag_a[ARC_W-1:0];
      div_req_a.divisor  = steps_ff;
      div_req_b.start    = div_start;
      div_req_b.dividend = mag_b[ARC_W-1:0];
      div_req_b.divisor  = steps_ff;
   end

   // point walk: quotient and remainder of |delta|*i/steps grow by the
   // per-step quotient and remainder, with one carry compare
   always_comb begin
      is_last = (index_ff == steps_ff);
      pos_a   = wrap_pos(start_a_ff, quo_a_ff, delta_a_ff[ANGLE_W-1]);
      pos_b   = wrap_pos(start_b_ff, quo_b_ff, delta_b_ff[ANGLE_W-1]);

      rsum_a  = {1'b0, rem_a_ff} + {1'b0, inc_r_a_ff};
      rsum_b  = {1'b0, rem_b_ff} + {1'b0, inc_r_b_ff};
      carry_a = (rsum_a >= {1'b0, steps_ff});
      carry_b = (rsum_b >= {1'b0, steps_ff});
      quo_a_in = ARC_W'(quo_a_ff + inc_q_a_ff + ARC_W'(carry_a));
      quo_b_in = ARC_W'(quo_b_ff + inc_q_b_ff + ARC_W'(carry_b));
      rem_a_in = carry_a ? INDEX_W'(rsum_a - {1'b0, steps_ff}) : rsum_a[INDEX_W-1:0];
      rem_b_in = carry_b ? INDEX_W'(rsum_b - {1'b0, steps_ff}) : rsum_b[INDEX_W-1:0];

      if (do_set) begin
         hand_a_in = pop_cmd.target_a;
         hand_b_in = pop_cmd.target_b;
      end else if (emit && is_last) begin
         hand_a_in = pos_a;
         hand_b_in = pos_b;
      end else begin
         hand_a_in = hand_a_ff;
         hand_b_in = hand_b_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hand_a_ff    <= '0;
         hand_b_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hand_a_ff    <= hand_a_in;
         hand_b_ff    <= hand_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_cmd) begin
         tgt_a_ff <= pop_cmd.target_a;
         tgt_b_ff <= pop_cmd.target_b;
      end
      if (do_pair) begin
         start_a_ff <= hand_a_ff;
         start_b_ff <= hand_b_ff;
         delta_a_ff <= pair_delta_a;
         delta_b_ff <= pair_delta_b;
         arc_ff     <= (pair_arc_b > pair_arc_a) ? pair_arc_b : pair_arc_a;
      end
      if (do_scale) begin
         steps_ff <= scale_steps;
      end
      if (div_latch) begin
         inc_q_a_ff <= div_rsp_a.quot;
         inc_r_a_ff <= div_rsp_a.rem;
         inc_q_b_ff <= div_rsp_b.quot;
         inc_r_b_ff <= div_rsp_b.rem;
         quo_a_ff   <= '0;
         rem_a_ff   <= '0;
         quo_b_ff   <= '0;
         rem_b_ff   <= '0;
         index_ff   <= '0;
      end else if (emit) begin
         quo_a_ff <= quo_a_in;
         rem_a_ff <= rem_a_in;
         quo_b_ff <= quo_b_in;
         rem_b_ff <= rem_b_in;
         index_ff <= INDEX_W'(index_ff + 1'b1);
      end
      if (emit) begin
         out_a_ff     <= pos_a;
         out_b_ff     <= pos_b;
         out_index_ff <= index_ff;
         out_last_ff  <= is_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_angle_a    = out_a_ff;
   assign rsp_angle_b    = out_b_ff;
   assign rsp_step_index = out_index_ff;
   assign rsp_last       = out_last_ff;

endmodule

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the two-hand shortest-arc mover core
// ---------------------------------------------------------------------------
// A directed part covers equal angles, exact opposite targets, targets folded
// back into one turn, pairing ties and swaps, moves across zero, and step
// counts both raised to one and saturated. Random moves and sets then run
// under several step rates. Both channels idle at random, the result side
// holds off once for a long stretch, and the sender drains the block once mid-phase.
// The scoreboard predicts every interpolation point and checks each one
// field by field, in order.
module testbench;
   import thsam_pkg::*;

   localparam int TURN          = int'(FULL_TURN);
   localparam int HALF          = int'(HALF_TURN);
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 38;
   localparam int PHASES        = 8;
   localparam int unsigned SPARE_INDEX = 1;
   localparam logic [CSR_ADDR_W-1:0] RATE_ADDR  = CSR_ADDR_W'({REG_STEP_RATE, 2'b00});
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(SPARE_INDEX * 4);

   typedef struct packed {
      logic [ANGLE_W-1:0] angle_a;
      logic [ANGLE_W-1:0] angle_b;
      logic [INDEX_W-1:0] step_index;
      logic               last;
   } point_type;

   class arc_scoreboard;
      logic [RATE_W-1:0]  rate;
      logic [ANGLE_W-1:0] hand_a;
      logic [ANGLE_W-1:0] hand_b;
      point_type          pending_points[$];
      int                 errors;
      int                 moves;
      int                 sets;
      int                 points;

      function new();
         rate   = RATE_RESET;
         hand_a = '0;
         hand_b = '0;
         errors = 0;
         moves  = 0;
         sets   = 0;
         points = 0;
      endfunction

      function int gap(input int x, input int y);
         return (x > y) ? x - y : y - x;
      endfunction

      function int wrap(input int v);
         return ((v % TURN) + TURN) % TURN;
      endfunction

      // signed shortest arc, exact opposites go backward
      function int arc_move(input int from, input int to);
         return ((to - from + 3 * HALF) % TURN) - HALF;
      endfunction

      function int arc_span(input int x, input int y);
         int d;
         d = gap(x, y) % TURN;
         return (d > HALF) ? TURN - d : d;
      endfunction

      function void note_command(input op_type op, input logic [ANGLE_W-1:0] raw_a,
                                 input logic [ANGLE_W-1:0] raw_b);
         int        ta;
         int        tb;
         int        sa;
         int        sb;
         int        da;
         int        db;
         int        span;
         int        steps;
         int        swap;
         point_type p;
         ta = int'(raw_a) % TURN;
         tb = int'(raw_b) % TURN;
         if (op == OP_SET) begin
            hand_a = ANGLE_W'(ta);
            hand_b = ANGLE_W'(tb);
            sets++;
            return;
         end
         moves++;
         sa = int'(hand_a);
         sb = int'(hand_b);
         // pairing by plain distance, swapped only when strictly cheaper
         if (gap(tb, sa) + gap(ta, sb) < gap(ta, sa) + gap(tb, sb)) begin
            swap = ta;
            ta   = tb;
            tb   = swap;
         end
         da   = arc_move(sa, ta);
         db   = arc_move(sb, tb);
         span = arc_span(ta, sa);
         if (arc_span(tb, sb) > span)
            span = arc_span(tb, sb);
         steps = (span * int'(rate)) >> STEP_SHIFT;
         if (steps < 1)
            steps = 1;
         if (steps > int'(MAX_STEPS))
            steps = int'(MAX_STEPS);
         for (int i = 0; i <= steps; i++) begin
            p.angle_a    = ANGLE_W'(wrap(sa + (da * i) / steps));
            p.angle_b    = ANGLE_W'(wrap(sb + (db * i) / steps));
            p.step_index = INDEX_W'(i);
            p.last       = (i == steps);
            pending_points.push_back(p);
         end
         hand_a = p.angle_a;
         hand_b = p.angle_b;
      endfunction

      function void check_point(input point_type got);
         point_type want;
         points++;
         if (pending_points.size() == 0) begin
            $error("point at index %0d arrived with no move waiting for it", got.step_index);
            errors++;
            return;
         end
         want = pending_points.pop_front();
         if (got.angle_a !== want.angle_a) begin
            $error("angle_a: expected %0d, got %0d", want.angle_a, got.angle_a);
            errors++;
         end
         if (got.angle_b !== want.angle_b) begin
            $error("angle_b: expected %0d, got %0d", want.angle_b, got.angle_b);
            errors++;
         end
         if (got.step_index !== want.step_index) begin
            $error("step_index: expected %0d, got %0d", want.step_index, got.step_index);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic                  req_op         = 1'b0;
   logic [ANGLE_W-1:0]    req_target_a   = '0;
   logic [ANGLE_W-1:0]    req_target_b   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [ANGLE_W-1:0]    rsp_angle_a;
   logic [ANGLE_W-1:0]    rsp_angle_b;
   logic [INDEX_W-1:0]    rsp_step_index;
   logic                  rsp_last;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   arc_scoreboard board;
   logic          steady_traffic = 1'b0;
   logic          hold_request   = 1'b0;
   int            csr_errors     = 0;
   int            rates_written  = 0;

   two_hand_shortest_arc_mover_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_target_a   (req_target_a),
      .req_target_b   (req_target_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_angle_a    (rsp_angle_a),
      .rsp_angle_b    (rsp_angle_b),
      .rsp_step_index (rsp_step_index),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_command(op_type'(req_op), req_target_a, req_target_b);
         if (rsp_valid && rsp_ready)
            board.check_point(point_type'({rsp_angle_a, rsp_angle_b, rsp_step_index,
                                           rsp_last}));
      end
   end

   // result side: random stalls, or one long hold-off when asked
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= steady_traffic || ($urandom_range(99) >= 31);
      end
   end

   task automatic send_command(input op_type op, input logic [ANGLE_W-1:0] target_a,
                               input logic [ANGLE_W-1:0] target_b);
      while (!steady_traffic && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_target_a <= target_a;
      req_target_b <= target_b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // also covers a set still queued after the last point
   task automatic wait_idle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (board.pending_points.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("step_rate readback: expected %0d, got %0d", want, csr_prdata);
         csr_errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_rate(input logic [RATE_W-1:0] rate);
      wait_idle();
      csr_write(RATE_ADDR, CSR_DATA_W'(rate));
      board.rate = rate;
      rates_written++;
      csr_read_check(RATE_ADDR, CSR_DATA_W'(rate));
   endtask

   // mostly in range, some folded targets, some short hops near the hand
   function automatic logic [ANGLE_W-1:0] pick_angle(input int near);
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return ANGLE_W'($urandom_range(8191, TURN));
      if (roll < 35)
         return ANGLE_W'((near + int'($urandom_range(160)) - 80 + TURN) % TURN);
      return ANGLE_W'($urandom_range(TURN - 1));
   endfunction

   task automatic random_command();
      op_type op;
      op = ($urandom_range(99) < 15) ? OP_SET : OP_MOVE;
      send_command(op, pick_angle(int'(board.hand_a)), pick_angle(int'(board.hand_b)));
   endtask

   initial begin : stimulus
      logic [RATE_W-1:0] phase_rates [PHASES];
      phase_rates = '{12'd4095, 12'd0, 12'd1, 12'd64, 12'd2048, 12'd300, 12'd0, 12'd0};
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset step rate first
      send_command(OP_MOVE, 13'd0, 13'd0);
      send_command(OP_MOVE, HALF_TURN, HALF_TURN);
      send_command(OP_SET, 13'd5759, 13'd8191);
      send_command(OP_MOVE, 13'd8191, 13'd5760);
      send_command(OP_SET, 13'd0, 13'd1000);
      send_command(OP_MOVE, 13'd1000, 13'd0);
      send_command(OP_SET, 13'd100, 13'd200);
      send_command(OP_MOVE, 13'd5700, 13'd5600);
      send_command(OP_MOVE, 13'd0, 13'd5759);
      set_rate(12'd0);
      send_command(OP_MOVE, 13'd2000, 13'd4000);
      set_rate(12'd4095);
      send_command(OP_MOVE, 13'd4880, 13'd1000);
      // write past the last register, rate must stay put
      wait_idle();
      csr_write(SPARE_ADDR, 32'd7);
      csr_read_check(RATE_ADDR, CSR_DATA_W'(board.rate));
      send_command(OP_MOVE, 13'd2000, 13'd3000);
      set_rate(12'd1);
      send_command(OP_MOVE, 13'd4880, 13'd200);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase >= PHASES - 2)
            set_rate(RATE_W'($urandom_range(4095)));
         else
            set_rate(phase_rates[phase]);
         steady_traffic = (phase == 4);
         if (phase == 2)
            hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == PHASE_ITEMS / 2)
               wait_idle();
            random_command();
         end
      end
      steady_traffic = 1'b0;

      wait_idle();
      $display("%0d commands (%0d moves, %0d sets) gave %0d checked points",
               board.moves + board.sets, board.moves, board.sets, board.points);
      $display("step rate was written %0d times, including both extremes", rates_written);
      if (board.errors == 0 && csr_errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin : watchdog
      #1600000;
      $display("Verification failed");
      $finish;
   end

endmodule
